// ----- design/hmis_pkg.sv -----
// Shared types, codes and constants of the 8-bit instruction step core.
// Used by every module of the block; depends on nothing else.
package hmis_pkg;

   localparam int DEF_MEM_BYTES = 256;
   localparam int REG_COUNT     = 16;
   localparam int REG_AW        = $clog2(REG_COUNT);

   // request kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   typedef enum logic [2:0] {
      ST_EXEC    = 3'd0,
      ST_HALT    = 3'd1,
      ST_INVALID = 3'd2,
      ST_NOINSTR = 3'd3,
      ST_LOADED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      STOP_RUN     = 2'd0,
      STOP_HALT    = 2'd1,
      STOP_INVALID = 2'd2,
      STOP_NOINSTR = 2'd3
   } stop_type;

   typedef enum logic [3:0] {
      OP_NONE  = 4'h0,
      OP_LOAD  = 4'h1,
      OP_IMM   = 4'h2,
      OP_STORE = 4'h3,
      OP_MOVE  = 4'h4,
      OP_ADD   = 4'h5,
      OP_FLOAT = 4'h6,
      OP_OR    = 4'h7,
      OP_AND   = 4'h8,
      OP_XOR   = 4'h9,
      OP_ROT   = 4'hA,
      OP_JUMP  = 4'hB,
      OP_HALT  = 4'hC
   } opcode_type;

   // one access to the main memory
   typedef struct packed {
      logic       en;
      logic       we;
      logic [7:0] addr;
      logic [7:0] wdata;
   } mem_req_type;

   // two reads and one write on the register file
   typedef struct packed {
      logic              rd_en;
      logic [REG_AW-1:0] rd_addr_a;
      logic [REG_AW-1:0] rd_addr_b;
      logic              we;
      logic [REG_AW-1:0] wr_addr;
      logic [7:0]        wr_data;
   } reg_req_type;

   // outcome of one executed instruction
   typedef struct packed {
      status_type        status;
      logic [7:0]        next_pc;
      logic              reg_we;
      logic [REG_AW-1:0] reg_num;
      logic [7:0]        reg_val;
      logic              mem_we;
      logic [7:0]        mem_addr;
      logic [7:0]        mem_val;
   } exec_out_type;

   function automatic status_type stop_to_status(input stop_type s);
      status_type r;
      unique case (s)
         STOP_RUN:     r = ST_EXEC;
         STOP_HALT:    r = ST_HALT;
         STOP_INVALID: r = ST_INVALID;
         STOP_NOINSTR: r = ST_NOINSTR;
         default:      r = ST_EXEC;
      endcase
      return r;
   endfunction

   function automatic stop_type status_to_stop(input status_type s);
      stop_type r;
      unique case (s)
         ST_HALT:    r = STOP_HALT;
         ST_INVALID: r = STOP_INVALID;
         ST_NOINSTR: r = STOP_NOINSTR;
         default:    r = STOP_RUN;
      endcase
      return r;
   endfunction

endpackage

// ----- design/hmis_mem.sv -----
// Main memory: single-port synchronous byte memory with a registered read.
// Per-entry valid bits make unwritten bytes read as zero after reset.
// Depends on hmis_pkg.
module hmis_mem
   import hmis_pkg::*;
#(
   parameter int MEM_BYTES = DEF_MEM_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type req,
   output logic [7:0]  rdata
);

   localparam int MemAw = $clog2(MEM_BYTES);

   logic [7:0]           mem_ff [MEM_BYTES];
   logic [MEM_BYTES-1:0] valid_ff;
   logic [7:0]           rdata_ff;
   logic                 in_range;
   logic [MemAw-1:0]     idx;

   assign in_range = ({1'b0, req.addr} < 9'(MEM_BYTES));
   assign idx      = req.addr[MemAw-1:0];
   assign rdata    = rdata_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (req.en && req.we && in_range) begin
         mem_ff[idx] <= req.wdata;
      end
      if (req.en && !req.we) begin
         rdata_ff <= (in_range && valid_ff[idx]) ? mem_ff[idx] : 8'd0;
      end
   end

   // written marks, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (req.en && req.we && in_range) begin
         valid_ff[idx] <= 1'b1;
      end
   end

endmodule

// ----- design/hmis_regfile.sv -----
// Register file: sixteen bytes, two registered read ports and one write port.
// Valid bits give zero for registers not yet written. Depends on hmis_pkg.
module hmis_regfile
   import hmis_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  reg_req_type req,
   output logic [7:0]  rdata_a,
   output logic [7:0]  rdata_b
);

   logic [7:0]           regs_ff [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [7:0]           rdata_a_ff;
   logic [7:0]           rdata_b_ff;

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

   // storage and registered reads
   always_ff @(posedge clock) begin
      if (req.we) begin
         regs_ff[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rdata_a_ff <= valid_ff[req.rd_addr_a] ? regs_ff[req.rd_addr_a] : 8'd0;
         rdata_b_ff <= valid_ff[req.rd_addr_b] ? regs_ff[req.rd_addr_b] : 8'd0;
      end
   end

   // written marks
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (req.we) begin
         valid_ff[req.wr_addr] <= 1'b1;
      end
   end

endmodule

// ----- design/hmis_exec.sv -----
// Instruction decode and execute: turns the fetched bytes and operands into
// the register, memory and pc updates of one step. Depends on hmis_pkg.
module hmis_exec
   import hmis_pkg::*;
#(
   parameter int MEM_BYTES = DEF_MEM_BYTES
) (
   input  logic [7:0]   pc,
   input  logic [7:0]   b0,
   input  logic [7:0]   b1,
   input  logic [7:0]   opnd_a,
   input  logic [7:0]   opnd_b,
   input  logic [7:0]   mem_data,
   output exec_out_type res
);

   opcode_type  op;
   logic [3:0]  r_fld;
   logic [3:0]  s_fld;
   logic [15:0] rot_w;
   logic        store_ok;

   assign op       = opcode_type'(b0[7:4]);
   assign r_fld    = b0[3:0];
   assign s_fld    = b1[7:4];
   assign rot_w    = {opnd_a, opnd_a} >> b1[2:0];
   assign store_ok = ({1'b0, b1} < 9'(MEM_BYTES));

   always_comb begin
      status_type st;
      logic       wr;
      logic [3:0] rn;
      logic [7:0] val;
      logic       mw;
      logic [7:0] nxt;

      st  = ST_EXEC;
      wr  = 1'b0;
      rn  = r_fld;
      val = 8'd0;
      mw  = 1'b0;
      nxt = pc + 8'd2;

      // decode
      unique case (op)
         OP_NONE:  st = ST_NOINSTR;
         OP_LOAD:  begin val = mem_data; wr = 1'b1; end
         OP_IMM:   begin val = b1; wr = 1'b1; end
         OP_STORE: mw = store_ok;
         OP_MOVE: begin
            if (r_fld != 4'd0) begin
               st = ST_INVALID;
            end else begin
               val = opnd_a;
               rn  = b1[3:0];
               wr  = 1'b1;
            end
         end
         OP_ADD:   begin val = opnd_a + opnd_b; wr = 1'b1; end
         OP_FLOAT: ;
         OP_OR:    begin val = opnd_a | opnd_b; wr = 1'b1; end
         OP_AND:   begin val = opnd_a & opnd_b; wr = 1'b1; end
         OP_XOR:   begin val = opnd_a ^ opnd_b; wr = 1'b1; end
         OP_ROT: begin
            if (s_fld != 4'd0) begin
               st = ST_INVALID;
            end else begin
               val = rot_w[7:0];
               wr  = 1'b1;
            end
         end
         OP_JUMP: begin
            if (opnd_a == opnd_b) begin
               nxt = b1;
            end
         end
         OP_HALT: begin
            if (r_fld != 4'd0 || b1 != 8'd0) begin
               st = ST_INVALID;
            end else begin
               st = ST_HALT;
            end
         end
         default:  st = ST_INVALID;
      endcase

      // a stopping instruction changes nothing but the stop state
      res.status   = st;
      res.next_pc  = (st == ST_EXEC) ? nxt : pc;
      res.reg_we   = (st == ST_EXEC) && wr;
      res.reg_num  = res.reg_we ? rn : 4'd0;
      res.reg_val  = res.reg_we ? val : 8'd0;
      res.mem_we   = (st == ST_EXEC) && mw;
      res.mem_addr = res.mem_we ? b1 : 8'd0;
      res.mem_val  = res.mem_we ? opnd_a : 8'd0;
   end

endmodule

// ----- design/hex_machine_instruction_step_core.sv -----
// Top level of the 8-bit instruction step core: sequencer, pc and stop state,
// response register. Uses hmis_pkg, hmis_mem, hmis_regfile and hmis_exec.
//
// Usage:
//   Requests enter on req_valid/req_stall with req_kind, req_load_address and
//   req_load_byte; a request is taken at a clock edge with req_valid high and
//   req_stall low. Each request gives exactly one response on rsp_valid/
//   rsp_stall, in request order.
//   A load request, a step while stopped and a step whose fetch runs past the
//   end of memory are answered at once: the response is valid the cycle after
//   the request is taken. For an executed step the two instruction bytes and
//   the data byte are read in turn on the single memory port, the register
//   operands alongside, then execute and write back. One request is in
//   flight at a time: after a step the next request waits for its write
//   back; after the others it can follow every cycle. A step is taken
//   while an earlier response waits in the output register; the others wait
//   until it leaves. When the receiver stalls, the response holds and the
//   execute stage waits without writing any state until the output register
//   is free. Reset clears pc, stop state, valid marks of memory and registers
//   (all read as zero) and the response register; no clearing pass is needed.
module hex_machine_instruction_step_core
   import hmis_pkg::*;
#(
   parameter int MEM_BYTES = DEF_MEM_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_load_address,
   input  logic [7:0] req_load_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_next_pc,
   output logic       rsp_reg_written,
   output logic [3:0] rsp_reg_number,
   output logic [7:0] rsp_reg_value,
   output logic       rsp_mem_written,
   output logic [7:0] rsp_mem_address,
   output logic [7:0] rsp_mem_value
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH_HI,
      S_FETCH_LO,
      S_EXEC
   } state_type;

   state_type    state_ff, state_in;
   logic [7:0]   pc_ff, pc_in;
   stop_type     stop_ff, stop_in;
   logic [7:0]   b0_ff, b0_in;
   logic [7:0]   b1_ff, b1_in;
   logic         rsp_valid_ff, rsp_valid_in;
   exec_out_type rsp_ff, rsp_in;

   mem_req_type  mem_req;
   reg_req_type  reg_req;
   logic [7:0]   mem_rdata;
   logic [7:0]   reg_rdata_a;
   logic [7:0]   reg_rdata_b;
   exec_out_type ex;

   logic         out_free;
   logic         past_end;
   logic         immediate;
   logic         accept;
   opcode_type   lo_op;

   hmis_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
      .clock (clock),
      .reset (reset),
      .req   (mem_req),
      .rdata (mem_rdata)
   );

   hmis_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .req     (reg_req),
      .rdata_a (reg_rdata_a),
      .rdata_b (reg_rdata_b)
   );

   hmis_exec #(.MEM_BYTES(MEM_BYTES)) u_exec (
      .pc       (pc_ff),
      .b0       (b0_ff),
      .b1       (b1_ff),
      .opnd_a   (reg_rdata_a),
      .opnd_b   (reg_rdata_b),
      .mem_data (mem_rdata),
      .res      (ex)
   );

   // request side handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign past_end  = (({1'b0, pc_ff} + 9'd1) >= 9'(MEM_BYTES));
   assign immediate = (req_kind == KIND_LOAD) || (stop_ff != STOP_RUN) || past_end;
   assign req_stall = (state_ff != S_IDLE) || (!out_free && immediate);
   assign accept    = req_valid && !req_stall;
   assign lo_op     = opcode_type'(b0_ff[7:4]);

   // sequencer next state, memory and register file accesses
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      stop_in      = stop_ff;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      mem_req = '0;
      reg_req = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // a request answered at once starts from a clean response
               if (immediate) begin
                  rsp_in         = '0;
                  rsp_in.next_pc = pc_ff;
               end
               if (req_kind == KIND_LOAD) begin
                  mem_req.en    = 1'b1;
                  mem_req.we    = 1'b1;
                  mem_req.addr  = req_load_address;
                  mem_req.wdata = req_load_byte;
                  rsp_in.status = ST_LOADED;
                  rsp_valid_in  = 1'b1;
               end else if (stop_ff != STOP_RUN) begin
                  rsp_in.status = stop_to_status(stop_ff);
                  rsp_valid_in  = 1'b1;
               end else if (past_end) begin
                  rsp_in.status = ST_NOINSTR;
                  stop_in       = STOP_NOINSTR;
                  rsp_valid_in  = 1'b1;
               end else begin
                  mem_req.en   = 1'b1;
                  mem_req.addr = pc_ff;
                  state_in     = S_FETCH_HI;
               end
            end
         end
         S_FETCH_HI: begin
            // first instruction byte arrives, fetch the second
            b0_in        = mem_rdata;
            mem_req.en   = 1'b1;
            mem_req.addr = pc_ff + 8'd1;
            state_in     = S_FETCH_LO;
         end
         S_FETCH_LO: begin
            // second byte arrives: data read and operand reads
            b1_in        = mem_rdata;
            mem_req.en   = 1'b1;
            mem_req.addr = mem_rdata;
            reg_req.rd_en = 1'b1;
            priority case (lo_op)
               OP_STORE, OP_ROT, OP_JUMP: reg_req.rd_addr_a = b0_ff[3:0];
               default:                   reg_req.rd_addr_a = mem_rdata[7:4];
            endcase
            reg_req.rd_addr_b = (lo_op == OP_JUMP) ? REG_AW'(0) : mem_rdata[3:0];
            state_in     = S_EXEC;
         end
         S_EXEC: begin
            // write back once the response register can take the result
            if (out_free) begin
               mem_req.en      = ex.mem_we;
               mem_req.we      = ex.mem_we;
               mem_req.addr    = ex.mem_addr;
               mem_req.wdata   = ex.mem_val;
               reg_req.we      = ex.reg_we;
               reg_req.wr_addr = ex.reg_num;
               reg_req.wr_data = ex.reg_val;
               pc_in           = ex.next_pc;
               stop_in         = status_to_stop(ex.status);
               rsp_in          = ex;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= 8'd0;
         stop_ff      <= STOP_RUN;
         b0_ff        <= 8'd0;
         b1_ff        <= 8'd0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         stop_ff      <= stop_in;
         b0_ff        <= b0_in;
         b1_ff        <= b1_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_next_pc     = rsp_ff.next_pc;
   assign rsp_reg_written = rsp_ff.reg_we;
   assign rsp_reg_number  = rsp_ff.reg_num;
   assign rsp_reg_value   = rsp_ff.reg_val;
   assign rsp_mem_written = rsp_ff.mem_we;
   assign rsp_mem_address = rsp_ff.mem_addr;
   assign rsp_mem_value   = rsp_ff.mem_val;

endmodule
